>>> design/cicm_pkg.sv
// ----------------------------------------------------------------------------
// cicm_pkg
// Shared types and constants for the cloud-in-cell mesh deposit block.
// ----------------------------------------------------------------------------
package cicm_pkg;

    localparam int MESH_SIZE = 32;
    localparam int IDX_W     = $clog2(MESH_SIZE);
    localparam int ADDR_W    = 3 * IDX_W;
    localparam int CELLS     = MESH_SIZE * MESH_SIZE * MESH_SIZE;
    localparam int W_W       = 17;

    localparam logic [31:0] CELL_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [16:0] WEIGHT_ONE     = 17'h1_0000;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_DEPOSIT = 3'd1;
    localparam logic [2:0] CMD_INTERP  = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_READ    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [2:0] REG_MESH_SIZE   = 3'd0;
    localparam logic [2:0] REG_MESH_SCALE  = 3'd1;
    localparam logic [2:0] REG_MASS_FACTOR = 3'd2;
    localparam logic [2:0] REG_SLAB_START  = 3'd3;
    localparam logic [2:0] REG_SLAB_WIDTH  = 3'd4;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic signed [31:0] cell_value;
    } cicm_req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } cicm_rsp_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [31:0] scale;
        logic [9:0]  mass;
        logic [4:0]  start;
        logic [6:0]  width;   // 0..MESH_SIZE
        logic [6:0]  n;       // 2..MESH_SIZE
    } cicm_cfg_t;

    // classified job passed from front to back
    typedef struct packed {
        logic [2:0]       command;
        logic [1:0]       xok;
        logic             bad;
        logic [IDX_W-1:0] x0, x1, y0, y1, z0, z1;
        logic [W_W-1:0]   wx0, wx1, wy0, wy1, wz0, wz1;
        logic [31:0]      cell_value;
    } cicm_job_t;

    typedef struct packed {
        logic valid;
        logic full;
    } cicm_qstat_t;

endpackage

>>> design/cicm_front.sv
// ----------------------------------------------------------------------------
// cicm_front
// Accept requests, scale positions to mesh units and classify into jobs.
// ----------------------------------------------------------------------------
module cicm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cicm_pkg::cicm_req_t req_data,
    input  cicm_pkg::cicm_cfg_t cfg,
    input  logic                hold,
    output logic                job_valid,
    input  logic                job_full,
    output cicm_pkg::cicm_job_t job
);
    import cicm_pkg::*;

    logic               s1_valid_reg, s2_valid_reg;
    cicm_req_t          s1_reg, s2_reg;
    logic signed [63:0] ux_reg, uy_reg, uz_reg;
    logic               s1_adv, s2_adv;

    logic signed [24:0] lx0, lx1;
    logic [IDX_W-1:0]   y0, y1, z0, z1;
    logic [15:0]        fx, fy, fz;

    assign s2_adv    = !s2_valid_reg || !job_full;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign req_stall = hold || !s1_adv;

    // advance the two request stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= req_valid && !hold;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // hold request payload and scaled positions
    always_ff @(posedge clk)
    begin
        if (s1_adv && req_valid && !hold)
            s1_reg <= req_data;
        if (s2_adv && s1_valid_reg)
        begin
            s2_reg <= s1_reg;
            ux_reg <= s1_reg.pos_x * $signed({1'b0, cfg.scale});
            uy_reg <= s1_reg.pos_y * $signed({1'b0, cfg.scale});
            uz_reg <= s1_reg.pos_z * $signed({1'b0, cfg.scale});
        end
    end

    function automatic logic [2*IDX_W+15:0] yz_axis(logic signed [63:0] u, logic [6:0] n);
        logic [22:0]      i;
        logic [15:0]      f;
        logic [IDX_W-1:0] i0, i1;
        i = u[63] ? 23'd0 : u[62:40];
        f = u[63] ? 16'd0 : u[39:24];
        i0 = ({16'd0, n} <= i) ? '0 : i[IDX_W-1:0];
        i1 = ({1'b0, i0} + 6'd1 >= n[5:0] + 6'd0 && n[6] == 1'b0) ? '0
             : IDX_W'(i0 + 1'b1);
        return {i0, i1, f};
    endfunction

    // derive indices and weights
    always_comb
    begin
        lx0 = $signed(ux_reg[63:40]) - $signed({20'd0, cfg.start});
        lx1 = lx0 + 25'sd1;
        fx  = ux_reg[39:24];
        {y0, y1, fy} = yz_axis(uy_reg, cfg.n);
        {z0, z1, fz} = yz_axis(uz_reg, cfg.n);

        job.command    = s2_reg.command;
        job.xok[0]     = !lx0[24] && (lx0 < $signed({18'd0, cfg.width}));
        job.xok[1]     = !lx1[24] && (lx1 < $signed({18'd0, cfg.width}));
        job.cell_value = s2_reg.cell_value;
        job.bad        = ({2'd0, s2_reg.cell_x} >= cfg.width)
                      || ({2'd0, s2_reg.cell_y} >= cfg.n)
                      || ({2'd0, s2_reg.cell_z} >= cfg.n);
        job.wx0 = WEIGHT_ONE - {1'b0, fx};
        job.wx1 = {1'b0, fx};
        job.wy0 = WEIGHT_ONE - {1'b0, fy};
        job.wy1 = {1'b0, fy};
        job.wz0 = WEIGHT_ONE - {1'b0, fz};
        job.wz1 = {1'b0, fz};
        if (s2_reg.command == CMD_WRITE || s2_reg.command == CMD_READ)
        begin
            job.x0 = s2_reg.cell_x;
            job.y0 = s2_reg.cell_y;
            job.z0 = s2_reg.cell_z;
        end
        else
        begin
            job.x0 = lx0[IDX_W-1:0];
            job.y0 = y0;
            job.z0 = z0;
        end
        job.x1 = lx1[IDX_W-1:0];
        job.y1 = y1;
        job.z1 = z1;
    end

    assign job_valid = s2_valid_reg;

endmodule

>>> design/cicm_queue.sv
// ----------------------------------------------------------------------------
// cicm_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module cicm_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  cicm_pkg::cicm_job_t   push_data,
    input  logic                  pop,
    output cicm_pkg::cicm_job_t   head,
    output cicm_pkg::cicm_qstat_t stat
);
    import cicm_pkg::*;

    cicm_job_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);
    assign head       = entry_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // store pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> design/cicm_back.sv
// ----------------------------------------------------------------------------
// cicm_back
// Mesh memory and sequencer that carries out one job at a time.
// ----------------------------------------------------------------------------
module cicm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cicm_pkg::cicm_qstat_t qstat,
    input  cicm_pkg::cicm_job_t   head,
    output logic                  pop,
    input  logic [9:0]            mass,
    output logic                  init_busy,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output cicm_pkg::cicm_rsp_t   rsp_data
);
    import cicm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DISP  = 9'b000000010,
        S_CLEAR = 9'b000000100,
        S_WXY   = 9'b000001000,
        S_WT    = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_CELL  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic               init_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [2:0]         corner_reg;
    logic               sat_reg, range_reg;
    logic signed [35:0] acc_reg;
    logic [31:0]        cellv_reg;
    cicm_job_t          job_reg;
    logic [16:0]        wxy_reg, wt_reg;
    logic [25:0]        add_reg;
    logic signed [49:0] prod_reg;
    logic               out_valid_reg;
    cicm_rsp_t          out_reg;

    logic [31:0]        mem [CELLS];
    logic [31:0]        mem_q;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_wa, mem_ra, corner_addr;
    logic [31:0]        mem_wd;

    logic [IDX_W-1:0]   cx, cy, cz;
    logic [W_W-1:0]     wxa, wyb, wzc;
    logic [33:0]        wxy_full, wt_full;
    logic signed [32:0] dep_sum;
    logic [31:0]        dep_val;
    logic               dep_sat;
    logic signed [31:0] int_val;
    logic               int_sat;
    logic               out_free, is_dep;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign init_busy = init_reg;
    assign pop       = (state_reg == S_IDLE) && qstat.valid;
    assign is_dep    = (job_reg.command == CMD_DEPOSIT);

    // select the current corner
    always_comb
    begin
        cx  = corner_reg[2] ? job_reg.x1 : job_reg.x0;
        cy  = corner_reg[1] ? job_reg.y1 : job_reg.y0;
        cz  = corner_reg[0] ? job_reg.z1 : job_reg.z0;
        wxa = corner_reg[2] ? job_reg.wx1 : job_reg.wx0;
        wyb = corner_reg[1] ? job_reg.wy1 : job_reg.wy0;
        wzc = corner_reg[0] ? job_reg.wz1 : job_reg.wz0;
        corner_addr = {cx, cy, cz};
        wxy_full = wxa * wyb;
        wt_full  = wxy_reg * wzc;
    end

    // deposit sum and interpolation saturation
    always_comb
    begin
        dep_sum = $signed({mem_q[31], mem_q}) + $signed({7'd0, add_reg});
        dep_sat = (dep_sum > 33'sh0_7FFF_FFFF) || (dep_sum < -33'sh0_8000_0000);
        if (dep_sum > 33'sh0_7FFF_FFFF)
            dep_val = 32'h7FFF_FFFF;
        else if (dep_sum < -33'sh0_8000_0000)
            dep_val = 32'h8000_0000;
        else
            dep_val = dep_sum[31:0];
        int_sat = (acc_reg > 36'sh0_7FFF_FFFF) || (acc_reg < -36'sh0_8000_0000);
        if (acc_reg > 36'sh0_7FFF_FFFF)
            int_val = 32'sh7FFF_FFFF;
        else if (acc_reg < -36'sh0_8000_0000)
            int_val = -32'sh8000_0000;
        else
            int_val = acc_reg[31:0];
    end

    // drive memory ports
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = corner_addr;
        mem_wd = dep_val;
        mem_re = 1'b0;
        mem_ra = corner_addr;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = CELL_MINUS_ONE;
            end
            S_DISP:
            begin
                mem_we = (job_reg.command == CMD_WRITE) && !job_reg.bad;
                mem_wd = job_reg.cell_value;
                mem_re = (job_reg.command == CMD_READ) && !job_reg.bad;
            end
            S_WT:  mem_re = 1'b1;
            S_ACC: mem_we = is_dep;
            default: ;
        endcase
    end

    // mesh store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (qstat.valid) state_next = S_DISP;
            S_DISP:
            begin
                case (job_reg.command)
                    CMD_CLEAR:   state_next = S_CLEAR;
                    CMD_DEPOSIT: state_next = S_WXY;
                    CMD_INTERP:  state_next = S_WXY;
                    CMD_READ:    state_next = job_reg.bad ? S_DONE : S_CELL;
                    default:     state_next = S_DONE;
                endcase
            end
            S_CLEAR:
                if (&clr_addr_reg)
                    state_next = init_reg ? S_IDLE : S_DONE;
            S_WXY:
                if (job_reg.xok[corner_reg[2]])
                    state_next = S_WT;
                else if (&corner_reg)
                    state_next = S_DONE;
            S_WT:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:  state_next = (&corner_reg) ? S_DONE : S_WXY;
            S_CELL: state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            init_reg      <= 1'b1;
            clr_addr_reg  <= '0;
            corner_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                    init_reg <= 1'b0;
            end
            if (state_reg == S_DISP)
                corner_reg <= 3'd0;
            else if ((state_reg == S_WXY && !job_reg.xok[corner_reg[2]])
                     || state_reg == S_ACC)
                corner_reg <= corner_reg + 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        case (state_reg)
            S_DISP:
            begin
                acc_reg   <= '0;
                sat_reg   <= 1'b0;
                cellv_reg <= '0;
                range_reg <= job_reg.bad
                             && (job_reg.command == CMD_WRITE || job_reg.command == CMD_READ);
            end
            S_WXY:  wxy_reg <= wxy_full[32:16];
            S_WT:   wt_reg  <= wt_full[32:16];
            S_MUL:
            begin
                add_reg  <= {16'd0, mass} * {9'd0, wt_reg};
                prod_reg <= $signed(mem_q) * $signed({1'b0, wt_reg});
            end
            S_ACC:
            begin
                if (is_dep)
                    sat_reg <= sat_reg || dep_sat;
                else
                    acc_reg <= acc_reg + {{2{prod_reg[49]}}, prod_reg[49:16]};
            end
            S_CELL: cellv_reg <= mem_q;
            default: ;
        endcase
        if (state_reg == S_DONE && out_free)
        begin
            if (job_reg.command == CMD_INTERP)
            begin
                out_reg.value  <= int_val;
                out_reg.status <= int_sat ? ST_SAT : ST_OK;
            end
            else
            begin
                out_reg.value  <= cellv_reg;
                out_reg.status <= range_reg ? ST_RANGE : (sat_reg ? ST_SAT : ST_OK);
            end
        end
    end

endmodule

>>> design/cic_mesh_deposit_and_interpolate.sv
// ----------------------------------------------------------------------------
// cic_mesh_deposit_and_interpolate
// Cloud-in-cell mesh with deposit, trilinear interpolate and cell access.
// ----------------------------------------------------------------------------
// The back end carries out one job at a time. Deposit and interpolate walk
// the eight corners; a corner whose x lies in the slab runs the multiply chain
// S_WXY, S_WT, S_MUL, S_ACC and the others are skipped. New requests are taken
// while a job runs until the front stages and the two-entry job queue fill.
// Clear and the pass after reset sweep 32768 cells, one per cycle; during
// the pass after reset the request side is stalled.
module cic_mesh_deposit_and_interpolate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                req_valid,
    output logic                req_stall,
    input  cicm_pkg::cicm_req_t req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cicm_pkg::cicm_rsp_t rsp_data
);
    import cicm_pkg::*;

    logic [5:0]  mesh_size_reg, slab_width_reg;
    logic [31:0] mesh_scale_reg;
    logic [9:0]  mass_factor_reg;
    logic [4:0]  slab_start_reg;
    logic [2:0]  reg_idx;
    cicm_cfg_t   cfg;
    logic        job_valid, pop, init_busy, push;
    cicm_job_t   job, head;
    cicm_qstat_t qstat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_size_reg   <= 6'd32;
            mesh_scale_reg  <= 32'd16777216;
            mass_factor_reg <= 10'd1;
            slab_start_reg  <= 5'd0;
            slab_width_reg  <= 6'd32;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MESH_SIZE:   mesh_size_reg   <= pwdata[5:0];
                REG_MESH_SCALE:  mesh_scale_reg  <= pwdata;
                REG_MASS_FACTOR: mass_factor_reg <= pwdata[9:0];
                REG_SLAB_START:  slab_start_reg  <= pwdata[4:0];
                REG_SLAB_WIDTH:  slab_width_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    // read back configuration registers
    always_comb
    begin
        case (reg_idx)
            REG_MESH_SIZE:   prdata = {26'd0, mesh_size_reg};
            REG_MESH_SCALE:  prdata = mesh_scale_reg;
            REG_MASS_FACTOR: prdata = {22'd0, mass_factor_reg};
            REG_SLAB_START:  prdata = {27'd0, slab_start_reg};
            REG_SLAB_WIDTH:  prdata = {26'd0, slab_width_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // clamp sizes to the mesh
    always_comb
    begin
        cfg.scale = mesh_scale_reg;
        cfg.mass  = mass_factor_reg;
        cfg.start = slab_start_reg;
        if (mesh_size_reg < 6'd2)
            cfg.n = 7'd2;
        else if ({1'b0, mesh_size_reg} > 7'(MESH_SIZE))
            cfg.n = 7'(MESH_SIZE);
        else
            cfg.n = {1'b0, mesh_size_reg};
        if ({1'b0, slab_width_reg} > 7'(MESH_SIZE))
            cfg.width = 7'(MESH_SIZE);
        else
            cfg.width = {1'b0, slab_width_reg};
    end

    assign push = job_valid && !qstat.full;

    cicm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .cfg       (cfg),
        .hold      (init_busy),
        .job_valid (job_valid),
        .job_full  (qstat.full),
        .job       (job)
    );

    cicm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (job),
        .pop       (pop),
        .head      (head),
        .stat      (qstat)
    );

    cicm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .mass      (cfg.mass),
        .init_busy (init_busy),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

`ifndef SYNTHESIS
    a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> req_stall)
        else $error("request taken during mesh initialization");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.status != 2'd3))
        else $error("undefined status code");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status == ST_RANGE) |-> (rsp_data.value == 32'sd0))
        else $error("nonzero value on range error");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qstat.valid)
        else $error("pop from empty job queue");
`endif

endmodule
